// File: rtl/core/itaf_pkg.sv
// Shared types, character codes and helper functions of the integer to ASCII formatter.
// This package has no dependencies. Every module of the block uses it.
package itaf_pkg;

    // Each kind of request has its own prefix text; a positive number has none.
    typedef enum logic [1:0] {
        K_NUM_POS = 2'd0,
        K_NUM_NEG = 2'd1,
        K_PTR     = 2'd2,
        K_NIL     = 2'd3
    } kind_t;

    // The request class that the front part hands to the back part.
    typedef struct packed {
        kind_t kind;
        logic  hex;
        logic  upper;
    } desc_t;

    // Operation codes of the operation input.
    localparam logic OP_NUMBER  = 1'b0;
    localparam logic OP_POINTER = 1'b1;

    // Digit style codes. Code 3 has no meaning and prints decimal.
    localparam logic [1:0] STYLE_DEC       = 2'd0;
    localparam logic [1:0] STYLE_HEX_LOWER = 2'd1;
    localparam logic [1:0] STYLE_HEX_UPPER = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_A_UPPER = 8'h41;
    localparam logic [7:0] CH_A_LOWER = 8'h61;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_N       = 8'h6e;
    localparam logic [7:0] CH_I       = 8'h69;
    localparam logic [7:0] CH_L       = 8'h6c;
    localparam logic [7:0] CH_X       = 8'h78;

    // Returns the number of prefix characters for a request kind.
    function automatic logic [2:0] prefix_len(kind_t kind);
        logic [2:0] len;
        case (kind)
            K_NUM_POS: len = 3'd0;
            K_NUM_NEG: len = 3'd1;
            K_PTR:     len = 3'd2;
            K_NIL:     len = 3'd5;
            default:   len = 3'd0;
        endcase
        return len;
    endfunction

    // Returns one character of the prefix text of a request kind.
    function automatic logic [7:0] prefix_char(kind_t kind, logic [2:0] idx);
        logic [7:0] ch;
        ch = CH_MINUS;
        case (kind)
            K_PTR:
            begin
                ch = (idx == 3'd0) ? CH_ZERO : CH_X;
            end
            K_NIL:
            begin
                case (idx)
                    3'd0:    ch = CH_LPAREN;
                    3'd1:    ch = CH_N;
                    3'd2:    ch = CH_I;
                    3'd3:    ch = CH_L;
                    default: ch = CH_RPAREN;
                endcase
            end
            default: ch = CH_MINUS;
        endcase
        return ch;
    endfunction

    // Returns the ASCII code of one digit in either letter case.
    function automatic logic [7:0] digit_char(logic [3:0] d, logic upper);
        logic [7:0] ch;
        if (d < 4'd10)
        begin
            ch = CH_ZERO + {4'h0, d};
        end
        else
        begin
            ch = (upper ? CH_A_UPPER : CH_A_LOWER) + {4'h0, d} - 8'd10;
        end
        return ch;
    endfunction

endpackage

// File: rtl/core/itaf_front.sv
// Front part of the integer to ASCII formatter: accepts requests and classifies them.
// Depends on itaf_pkg for the request class type and the operation and style codes.
module itaf_front #(
    parameter int VALUE_BITS = 64
) (
    input  logic                      start,
    input  logic                      busy,
    input  logic                      operation,
    input  logic [63:0]               value,
    input  logic [1:0]                digit_style,
    output logic                      push,
    output itaf_pkg::desc_t           desc,
    output logic [VALUE_BITS-1:0]     mag
);

    logic [VALUE_BITS-1:0] v;

    assign v    = value[VALUE_BITS-1:0];
    assign push = start && !busy;

    // A negative number keeps its magnitude as an unsigned value, so the most
    // negative value comes out as the full power of two.
    always_comb
    begin
        desc.hex   = 1'b1;
        desc.upper = 1'b0;
        mag        = v;
        if (operation == itaf_pkg::OP_POINTER)
        begin
            desc.kind = (v == '0) ? itaf_pkg::K_NIL : itaf_pkg::K_PTR;
        end
        else
        begin
            desc.hex   = (digit_style == itaf_pkg::STYLE_HEX_LOWER) ||
                         (digit_style == itaf_pkg::STYLE_HEX_UPPER);
            desc.upper = (digit_style == itaf_pkg::STYLE_HEX_UPPER);
            if (v[VALUE_BITS-1])
            begin
                desc.kind = itaf_pkg::K_NUM_NEG;
                mag       = ~v + {{(VALUE_BITS-1){1'b0}}, 1'b1};
            end
            else
            begin
                desc.kind = itaf_pkg::K_NUM_POS;
            end
        end
    end

endmodule

// File: rtl/core/itaf_queue.sv
// Short request queue between the front and back parts of the formatter.
// Depends on itaf_pkg for the request class type and the queue depth.
module itaf_queue #(
    parameter int VALUE_BITS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  itaf_pkg::desc_t                  push_desc,
    input  logic [VALUE_BITS-1:0]            push_mag,
    input  logic                             pop,
    output itaf_pkg::desc_t                  pop_desc,
    output logic [VALUE_BITS-1:0]            pop_mag,
    output logic                             empty,
    output logic                             full,
    output logic [itaf_pkg::QUEUE_CNT_W-1:0] count
);

    localparam int DEPTH = itaf_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = itaf_pkg::QUEUE_CNT_W;

    itaf_pkg::desc_t       desc_mem [DEPTH];
    logic [VALUE_BITS-1:0] mag_mem  [DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg;
    logic [PTR_W-1:0]      rd_ptr_reg;
    logic [CNT_W-1:0]      count_reg;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign count    = count_reg;
    assign pop_desc = desc_mem[rd_ptr_reg];
    assign pop_mag  = mag_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            desc_mem[wr_ptr_reg] <= push_desc;
            mag_mem[wr_ptr_reg]  <= push_mag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/itaf_back.sv
// Back part of the formatter: converts a queued request to digits and emits its characters.
// Depends on itaf_pkg for the request class type, character codes and helper functions.
module itaf_back #(
    parameter int VALUE_BITS = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_empty,
    input  itaf_pkg::desc_t           q_desc,
    input  logic [VALUE_BITS-1:0]     q_mag,
    output logic                      pop,
    output logic                      strobe,
    output logic [7:0]                char_code,
    output logic                      last_char
);

    // Decimal digits needed for the largest value, and hex digits likewise.
    localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
    localparam int NDIG       = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
    localparam int DW         = NDIG * 4;
    localparam int DCNT_W     = $clog2(NDIG + 1);
    localparam int BCNT_W     = $clog2(VALUE_BITS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_PREFIX,
        S_DIGITS
    } state_t;

    state_t                state_reg,  state_next;
    itaf_pkg::desc_t       desc_reg,   desc_next;
    logic [DW-1:0]         digits_reg, digits_next;
    logic [VALUE_BITS-1:0] bin_reg,    bin_next;
    logic [BCNT_W-1:0]     bcnt_reg,   bcnt_next;
    logic [DCNT_W-1:0]     dcnt_reg,   dcnt_next;
    logic [2:0]            pidx_reg,   pidx_next;
    logic                  strobe_reg, strobe_next;
    logic [7:0]            char_reg,   char_next;
    logic                  last_reg,   last_next;

    logic [DW-1:0]         adjusted;
    logic [3:0]            top_digit;
    logic [2:0]            plen;

    assign top_digit = digits_reg[DW-1 -: 4];
    assign plen      = itaf_pkg::prefix_len(desc_reg.kind);
    assign strobe    = strobe_reg;
    assign char_code = char_reg;
    assign last_char = last_reg;

    // Add-three step of the binary to BCD conversion, once per digit.
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            adjusted[4*i +: 4] = (digits_reg[4*i +: 4] >= 4'd5) ?
                                 4'(digits_reg[4*i +: 4] + 4'd3) : digits_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        desc_next   = desc_reg;
        digits_next = digits_reg;
        bin_next    = bin_reg;
        bcnt_next   = bcnt_reg;
        dcnt_next   = dcnt_reg;
        pidx_next   = pidx_reg;
        strobe_next = 1'b0;
        char_next   = char_reg;
        last_next   = 1'b0;
        pop         = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    pop         = 1'b1;
                    desc_next   = q_desc;
                    pidx_next   = '0;
                    dcnt_next   = DCNT_W'(NDIG);
                    bin_next    = q_mag;
                    bcnt_next   = BCNT_W'(VALUE_BITS);
                    if (q_desc.kind == itaf_pkg::K_NIL)
                    begin
                        state_next = S_PREFIX;
                    end
                    else if (q_desc.hex)
                    begin
                        digits_next = DW'(q_mag);
                        state_next  = S_SKIP;
                    end
                    else
                    begin
                        digits_next = '0;
                        state_next  = S_CONV;
                    end
                end
            end
            S_CONV:
            begin
                digits_next = {adjusted[DW-2:0], bin_reg[VALUE_BITS-1]};
                bin_next    = bin_reg << 1;
                bcnt_next   = bcnt_reg - 1'b1;
                if (bcnt_reg == BCNT_W'(1))
                begin
                    state_next = S_SKIP;
                end
            end
            S_SKIP:
            begin
                // Leading zeros go one digit a cycle; a lone zero stays.
                if ((top_digit == 4'd0) && (dcnt_reg > DCNT_W'(1)))
                begin
                    digits_next = {digits_reg[DW-5:0], 4'h0};
                    dcnt_next   = dcnt_reg - 1'b1;
                end
                else
                begin
                    state_next = (plen != 3'd0) ? S_PREFIX : S_DIGITS;
                end
            end
            S_PREFIX:
            begin
                strobe_next = 1'b1;
                char_next   = itaf_pkg::prefix_char(desc_reg.kind, pidx_reg);
                pidx_next   = pidx_reg + 1'b1;
                if (pidx_reg == plen - 3'd1)
                begin
                    if (desc_reg.kind == itaf_pkg::K_NIL)
                    begin
                        last_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_DIGITS;
                    end
                end
            end
            S_DIGITS:
            begin
                strobe_next = 1'b1;
                char_next   = itaf_pkg::digit_char(top_digit, desc_reg.upper);
                last_next   = (dcnt_reg == DCNT_W'(1));
                digits_next = {digits_reg[DW-5:0], 4'h0};
                dcnt_next   = dcnt_reg - 1'b1;
                if (dcnt_reg == DCNT_W'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            strobe_reg <= 1'b0;
            char_reg   <= '0;
            last_reg   <= 1'b0;
            bcnt_reg   <= '0;
            dcnt_reg   <= '0;
            pidx_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            char_reg   <= char_next;
            last_reg   <= last_next;
            bcnt_reg   <= bcnt_next;
            dcnt_reg   <= dcnt_next;
            pidx_reg   <= pidx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg   <= desc_next;
        digits_reg <= digits_next;
        bin_reg    <= bin_next;
    end

endmodule

// File: rtl/core/integer_to_ascii_formatter.sv
// Flow: the back part takes a request from the queue whenever it is idle. Decimal requests
// pass through the bit-serial BCD converter; every numeric request then drops the leading
// zeros of its NDIG-digit buffer (NDIG is 20 at 64 bits), and the prefix and the digits
// follow, one character per cycle. The back part handles one request at a time; busy is a
// full queue.
module integer_to_ascii_formatter #(
    parameter int VALUE_BITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        operation,
    input  logic [63:0] value,
    input  logic [1:0]  digit_style,
    output logic        strobe,
    output logic [7:0]  char_code,
    output logic        last_char
);

    // Reset: rst_n clears the queue and the back part; no clearing pass is needed.
    // The front part classifies each request in the cycle it is accepted: it picks
    // the prefix kind, the radix and letter case, and forms the unsigned magnitude.
    // The result is written into a short queue so the front side keeps accepting
    // requests while the back side is still converting or emitting characters.
    localparam int CNT_W = itaf_pkg::QUEUE_CNT_W;

    logic                  push;
    itaf_pkg::desc_t       f_desc;
    logic [VALUE_BITS-1:0] f_mag;
    logic                  pop;
    itaf_pkg::desc_t       q_desc;
    logic [VALUE_BITS-1:0] q_mag;
    logic                  q_empty;
    logic                  q_full;
    logic [CNT_W-1:0]      q_count;

    // The block is busy only when the queue has no free entry.
    assign busy = q_full;

    itaf_front #(
        .VALUE_BITS(VALUE_BITS)
    ) u_front (
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .value      (value),
        .digit_style(digit_style),
        .push       (push),
        .desc       (f_desc),
        .mag        (f_mag)
    );

    itaf_queue #(
        .VALUE_BITS(VALUE_BITS)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_desc(f_desc),
        .push_mag (f_mag),
        .pop      (pop),
        .pop_desc (q_desc),
        .pop_mag  (q_mag),
        .empty    (q_empty),
        .full     (q_full),
        .count    (q_count)
    );

    // The back part converts decimal requests bit-serially to BCD, strips leading
    // zeros one digit a cycle, then emits the prefix and the digits from registered
    // outputs, one character per cycle, with last_char on the final one.
    itaf_back #(
        .VALUE_BITS(VALUE_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_desc   (q_desc),
        .q_mag    (q_mag),
        .pop      (pop),
        .strobe   (strobe),
        .char_code(char_code),
        .last_char(last_char)
    );

    // An accepted request is in the queue in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (q_count != '0))
    else $error("accepted request did not enter the queue");

    // The back part returns to idle after the final character of a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last_char) |=> !strobe)
    else $error("character emitted right after the final character");

    // Every emitted character lies between the left parenthesis and the letter x.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> ((char_code >= itaf_pkg::CH_LPAREN) && (char_code <= itaf_pkg::CH_X)))
    else $error("emitted character outside the formatter's character set");

    // The back part never takes a request from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty)
    else $error("request taken from an empty queue");

endmodule
